FILE: hw/rtl/acpe_pkg.sv
// Shared types and constants of the compressed position encoder.
// Holds the transfer payload structs, the reciprocal constants for the
// constant divisions and the base-91 helper. Depends on nothing.
package acpe_pkg;

    localparam int unsigned VAL_W   = 31;
    localparam int unsigned SCALE_W = 27;
    localparam int unsigned DIGIT_W = 7;
    localparam int unsigned NDIGITS = 4;
    localparam int unsigned NCHARS  = 13;
    localparam int unsigned CNT_W   = $clog2(NCHARS);

    localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
    localparam logic signed [31:0] LAT_BIAS  = 32'sd900000000;
    localparam logic signed [32:0] LON_LIMIT = 33'sd1800000000;

    localparam int unsigned DIV26_SHIFT  = 36;
    localparam int unsigned DIV2710_SHIFT = 43;
    localparam int unsigned DIVBIG_SHIFT = 55;
    localparam int unsigned DIV91_SHIFT  = 34;

    localparam logic [31:0] DIV26_MUL =
        32'(((64'd1 << DIV26_SHIFT) + 64'd26 - 64'd1) / 64'd26);
    localparam logic [31:0] DIV2710_MUL =
        32'(((64'd1 << DIV2710_SHIFT) + 64'd2710 - 64'd1) / 64'd2710);
    localparam logic [31:0] DIVBIG_MUL =
        32'(((64'd1 << DIVBIG_SHIFT) + 64'd15384615 - 64'd1) / 64'd15384615);
    localparam logic [27:0] DIV91_MUL =
        28'(((64'd1 << DIV91_SHIFT) + 64'd91 - 64'd1) / 64'd91);

    localparam logic [DIGIT_W-1:0] B91     = 7'd91;
    localparam logic [7:0]         B91_OFS = 8'd33;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_G     = 8'h47;

    localparam logic [7:0] OVERLAY_RESET = 8'd47;
    localparam logic [7:0] SYMBOL_RESET  = 8'd79;

    localparam logic REG_OVERLAY = 1'b0;
    localparam logic REG_SYMBOL  = 1'b1;

    typedef struct packed {
        logic signed [30:0] lat_e7;
        logic signed [31:0] lon_e7;
    } pos_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } chr_t;

    typedef struct packed {
        logic [7:0] overlay_char;
        logic [7:0] symbol_char;
    } cfg_t;

    typedef struct packed {
        logic [SCALE_W-1:0] lat;
        logic [SCALE_W-1:0] lon;
    } scaled_t;

    typedef struct packed {
        logic [NDIGITS-1:0][DIGIT_W-1:0] lat;
        logic [NDIGITS-1:0][DIGIT_W-1:0] lon;
    } digits_t;

    function automatic logic [SCALE_W-1:0] div91(input logic [SCALE_W-1:0] x);
        logic [SCALE_W+27:0] prod;
        prod = (SCALE_W + 28)'(x) * (SCALE_W + 28)'(DIV91_MUL);
        return SCALE_W'(prod >> DIV91_SHIFT);
    endfunction

endpackage

FILE: hw/rtl/acpe_regs.sv
// Configuration registers behind the APB-style port.
// Holds the overlay and symbol bytes. Depends on acpe_pkg.
module acpe_regs
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output acpe_pkg::cfg_t   cfg
);

    acpe_pkg::cfg_t cfg_reg;
    acpe_pkg::cfg_t cfg_next;
    logic           wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (paddr[2])
                acpe_pkg::REG_OVERLAY: cfg_next.overlay_char = pwdata[7:0];
                acpe_pkg::REG_SYMBOL:  cfg_next.symbol_char  = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            acpe_pkg::REG_OVERLAY: prdata = {24'd0, cfg_reg.overlay_char};
            acpe_pkg::REG_SYMBOL:  prdata = {24'd0, cfg_reg.symbol_char};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlay_char <= acpe_pkg::OVERLAY_RESET;
            cfg_reg.symbol_char  <= acpe_pkg::SYMBOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/acpe_scale.sv
// Front pipeline: clamp and bias the position, then scale each value by
// v/26 - v/2710 + v/15384615 with reciprocal multiplies. Depends on acpe_pkg.
module acpe_scale
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  acpe_pkg::pos_t      up_data,
    output logic                up_stall,
    output logic                dn_valid,
    output acpe_pkg::scaled_t   dn_data,
    input  logic                dn_stall
);

    localparam int unsigned PW = acpe_pkg::VAL_W + 32;

    logic                                s1_vld_reg;
    logic [1:0][acpe_pkg::VAL_W-1:0]     s1_v_reg;
    logic [1:0][acpe_pkg::VAL_W-1:0]     s1_v_next;
    logic                                s2_vld_reg;
    logic [1:0][acpe_pkg::SCALE_W-1:0]   s2_q26_reg;
    logic [1:0][19:0]                    s2_q2710_reg;
    logic [1:0][6:0]                     s2_qbig_reg;
    logic [1:0][acpe_pkg::SCALE_W-1:0]   s2_q26_next;
    logic [1:0][19:0]                    s2_q2710_next;
    logic [1:0][6:0]                     s2_qbig_next;
    logic                                s3_vld_reg;
    logic [1:0][acpe_pkg::SCALE_W-1:0]   s3_sc_reg;
    logic [1:0][acpe_pkg::SCALE_W-1:0]   s3_sc_next;
    logic                                rdy1;
    logic                                rdy2;
    logic                                rdy3;
    logic signed [31:0]                  lat_w;
    logic signed [31:0]                  lat_c;
    logic signed [32:0]                  lon_w;
    logic signed [32:0]                  lon_c;
    logic signed [32:0]                  lon_sum;
    logic signed [31:0]                  lat_diff;

    assign rdy3     = !s3_vld_reg || !dn_stall;
    assign rdy2     = !s2_vld_reg || rdy3;
    assign rdy1     = !s1_vld_reg || rdy2;
    assign up_stall = !rdy1;
    assign dn_valid = s3_vld_reg;
    assign dn_data.lat = s3_sc_reg[0];
    assign dn_data.lon = s3_sc_reg[1];

    always_comb
    begin
        lat_w = 32'(up_data.lat_e7);
        lon_w = 33'(up_data.lon_e7);
        if (lat_w > acpe_pkg::LAT_LIMIT)
            lat_c = acpe_pkg::LAT_LIMIT;
        else if (lat_w < -acpe_pkg::LAT_LIMIT)
            lat_c = -acpe_pkg::LAT_LIMIT;
        else
            lat_c = lat_w;
        if (lon_w > acpe_pkg::LON_LIMIT)
            lon_c = acpe_pkg::LON_LIMIT;
        else if (lon_w < -acpe_pkg::LON_LIMIT)
            lon_c = -acpe_pkg::LON_LIMIT;
        else
            lon_c = lon_w;
        lat_diff     = acpe_pkg::LAT_BIAS - lat_c;
        lon_sum      = lon_c + acpe_pkg::LON_LIMIT;
        s1_v_next[0] = acpe_pkg::VAL_W'(lat_diff);
        s1_v_next[1] = acpe_pkg::VAL_W'(lon_sum[32:1]);
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s2_q26_next[i]   = acpe_pkg::SCALE_W'((PW'(s1_v_reg[i])
                               * PW'(acpe_pkg::DIV26_MUL)) >> acpe_pkg::DIV26_SHIFT);
            s2_q2710_next[i] = 20'((PW'(s1_v_reg[i])
                               * PW'(acpe_pkg::DIV2710_MUL)) >> acpe_pkg::DIV2710_SHIFT);
            s2_qbig_next[i]  = 7'((PW'(s1_v_reg[i])
                               * PW'(acpe_pkg::DIVBIG_MUL)) >> acpe_pkg::DIVBIG_SHIFT);
            s3_sc_next[i]    = s2_q26_reg[i] - acpe_pkg::SCALE_W'(s2_q2710_reg[i])
                               + acpe_pkg::SCALE_W'(s2_qbig_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_vld_reg <= up_valid;
            if (rdy2)
                s2_vld_reg <= s1_vld_reg;
            if (rdy3)
                s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_v_reg <= s1_v_next;
        if (rdy2)
        begin
            s2_q26_reg   <= s2_q26_next;
            s2_q2710_reg <= s2_q2710_next;
            s2_qbig_reg  <= s2_qbig_next;
        end
        if (rdy3)
            s3_sc_reg <= s3_sc_next;
    end

endmodule

FILE: hw/rtl/acpe_digits.sv
// Base-91 split pipeline: one reciprocal divide by 91 per stage but the last, four
// digits per value, two values side by side. Depends on acpe_pkg.
module acpe_digits
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  acpe_pkg::scaled_t   up_data,
    output logic                up_stall,
    output logic                dn_valid,
    output acpe_pkg::digits_t   dn_data,
    input  logic                dn_stall
);

    localparam int unsigned SW   = acpe_pkg::SCALE_W;
    localparam int unsigned DW   = acpe_pkg::DIGIT_W;
    localparam int unsigned NDIG = acpe_pkg::NDIGITS;

    logic                  d1_vld_reg;
    logic [1:0][SW-1:0]    d1_s_reg;
    logic [1:0][19:0]      d1_q1_reg;
    logic                  d2_vld_reg;
    logic [1:0][DW-1:0]    d2_r0_reg;
    logic [1:0][19:0]      d2_q1_reg;
    logic [1:0][13:0]      d2_q2_reg;
    logic                  d3_vld_reg;
    logic [1:0][DW-1:0]    d3_r0_reg;
    logic [1:0][DW-1:0]    d3_r1_reg;
    logic [1:0][13:0]      d3_q2_reg;
    logic [1:0][DW-1:0]    d3_q3_reg;
    logic                  d4_vld_reg;
    logic [1:0][NDIG-1:0][DW-1:0] d4_dig_reg;
    logic [1:0][SW-1:0]    d1_s_next;
    logic [1:0][19:0]      d1_q1_next;
    logic [1:0][DW-1:0]    d2_r0_next;
    logic [1:0][13:0]      d2_q2_next;
    logic [1:0][DW-1:0]    d3_r1_next;
    logic [1:0][DW-1:0]    d3_q3_next;
    logic [1:0][NDIG-1:0][DW-1:0] d4_dig_next;
    logic                  rdy1;
    logic                  rdy2;
    logic                  rdy3;
    logic                  rdy4;

    assign rdy4     = !d4_vld_reg || !dn_stall;
    assign rdy3     = !d3_vld_reg || rdy4;
    assign rdy2     = !d2_vld_reg || rdy3;
    assign rdy1     = !d1_vld_reg || rdy2;
    assign up_stall = !rdy1;
    assign dn_valid = d4_vld_reg;
    assign dn_data.lat = d4_dig_reg[0];
    assign dn_data.lon = d4_dig_reg[1];

    always_comb
    begin
        d1_s_next[0] = up_data.lat;
        d1_s_next[1] = up_data.lon;
        for (int i = 0; i < 2; i++)
        begin
            d1_q1_next[i] = 20'(acpe_pkg::div91(d1_s_next[i]));
            d2_r0_next[i] = DW'(d1_s_reg[i] - SW'(d1_q1_reg[i]) * SW'(acpe_pkg::B91));
            d2_q2_next[i] = 14'(acpe_pkg::div91(SW'(d1_q1_reg[i])));
            d3_r1_next[i] = DW'(d2_q1_reg[i] - 20'(d2_q2_reg[i]) * 20'(acpe_pkg::B91));
            d3_q3_next[i] = DW'(acpe_pkg::div91(SW'(d2_q2_reg[i])));
            d4_dig_next[i][3] = d3_q3_reg[i];
            d4_dig_next[i][2] = DW'(d3_q2_reg[i] - 14'(d3_q3_reg[i]) * 14'(acpe_pkg::B91));
            d4_dig_next[i][1] = d3_r1_reg[i];
            d4_dig_next[i][0] = d3_r0_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
            d4_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                d1_vld_reg <= up_valid;
            if (rdy2)
                d2_vld_reg <= d1_vld_reg;
            if (rdy3)
                d3_vld_reg <= d2_vld_reg;
            if (rdy4)
                d4_vld_reg <= d3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            d1_s_reg  <= d1_s_next;
            d1_q1_reg <= d1_q1_next;
        end
        if (rdy2)
        begin
            d2_r0_reg <= d2_r0_next;
            d2_q1_reg <= d1_q1_reg;
            d2_q2_reg <= d2_q2_next;
        end
        if (rdy3)
        begin
            d3_r0_reg <= d2_r0_reg;
            d3_r1_reg <= d3_r1_next;
            d3_q2_reg <= d2_q2_reg;
            d3_q3_reg <= d3_q3_next;
        end
        if (rdy4)
            d4_dig_reg <= d4_dig_next;
    end

endmodule

FILE: hw/rtl/acpe_serializer.sv
// Output stage: assemble the thirteen characters of one position and
// shift them out one per transfer. Depends on acpe_pkg.
module acpe_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  acpe_pkg::cfg_t      cfg,
    input  logic                up_valid,
    input  acpe_pkg::digits_t   up_data,
    output logic                up_stall,
    output logic                chr_valid,
    output acpe_pkg::chr_t      chr,
    input  logic                chr_stall
);

    localparam int unsigned NCH  = acpe_pkg::NCHARS;
    localparam int unsigned CW   = acpe_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(NCH - 1);

    logic                    vld_reg;
    logic [CW-1:0]           cnt_reg;
    logic [NCH-1:0][7:0]     chars_reg;
    logic [NCH-1:0][7:0]     chars_next;
    logic                    fire;
    logic                    load;
    logic                    is_last;

    assign is_last   = cnt_reg == LAST_IDX;
    assign fire      = vld_reg && !chr_stall;
    assign load      = !vld_reg || (fire && is_last);
    assign up_stall  = !load;
    assign chr_valid = vld_reg;
    assign chr.out_char  = chars_reg[0];
    assign chr.last_char = is_last;

    always_comb
    begin
        chars_next[0] = cfg.overlay_char;
        for (int i = 0; i < acpe_pkg::NDIGITS; i++)
        begin
            chars_next[1 + i] = 8'(up_data.lat[acpe_pkg::NDIGITS - 1 - i])
                                + acpe_pkg::B91_OFS;
            chars_next[5 + i] = 8'(up_data.lon[acpe_pkg::NDIGITS - 1 - i])
                                + acpe_pkg::B91_OFS;
        end
        chars_next[9]  = cfg.symbol_char;
        chars_next[10] = acpe_pkg::CHAR_SPACE;
        chars_next[11] = acpe_pkg::CHAR_X;
        chars_next[12] = acpe_pkg::CHAR_G;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= up_valid;
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            chars_reg <= chars_next;
        else if (fire)
            chars_reg <= {8'd0, chars_reg[NCH-1:1]};
    end

endmodule

FILE: hw/rtl/aprs_compressed_position_encoder.sv
// Compressed position encoder top level: register port, scaling pipeline,
// base-91 pipeline and character serializer. Depends on acpe_pkg and the
// acpe_regs, acpe_scale, acpe_digits and acpe_serializer modules.
//
// Each accepted position yields thirteen characters, one per output transfer,
// with last_char set on the thirteenth. The position passes eight registers
// (three scaling stages, four digit stages, one load into the serializer), the
// first of them written at the input transfer edge and the last holding the
// characters offered at the output. The byte-wide output sets the sustained
// rate; the seven pipeline stages accept a new position every cycle until
// they fill, so up to eight positions can be in flight while the serializer
// drains. Configuration writes take effect for positions reaching the
// serializer after the write.
module aprs_compressed_position_encoder
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             pos_valid,
    input  acpe_pkg::pos_t   pos,
    output logic             pos_stall,
    output logic             chr_valid,
    output acpe_pkg::chr_t   chr,
    input  logic             chr_stall
);

    acpe_pkg::cfg_t      cfg;
    logic                sc_valid;
    acpe_pkg::scaled_t   sc_data;
    logic                sc_stall;
    logic                dg_valid;
    acpe_pkg::digits_t   dg_data;
    logic                dg_stall;

    acpe_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acpe_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pos_valid),
        .up_data  (pos),
        .up_stall (pos_stall),
        .dn_valid (sc_valid),
        .dn_data  (sc_data),
        .dn_stall (sc_stall)
    );

    acpe_digits u_digits
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sc_valid),
        .up_data  (sc_data),
        .up_stall (sc_stall),
        .dn_valid (dg_valid),
        .dn_data  (dg_data),
        .dn_stall (dg_stall)
    );

    acpe_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (dg_valid),
        .up_data   (dg_data),
        .up_stall  (dg_stall),
        .chr_valid (chr_valid),
        .chr       (chr),
        .chr_stall (chr_stall)
    );

endmodule
